// ===== sv/tpm_pkg.sv =====
package tpm_pkg;

  localparam int unsigned ReadingW = 8;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [ReadingW-1:0] reading_t;
  typedef logic [CountW-1:0]   count_t;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    REG_PEDAL_PAIR_MAX_DIFF    = 3'd0,
    REG_THROTTLE_PAIR_MAX_DIFF = 3'd1,
    REG_CROSS_MAX_DIFF         = 3'd2,
    REG_CROSS_ENABLE_LEVEL     = 3'd3,
    REG_PAIR_FAULT_LIMIT       = 3'd4,
    REG_CROSS_FAULT_LIMIT      = 3'd5
  } cfg_idx_t;

  // Item kinds
  localparam logic MODE_SENSOR = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  // Register reset values
  localparam reading_t RST_PEDAL_PAIR_MAX_DIFF    = 8'd10;
  localparam reading_t RST_THROTTLE_PAIR_MAX_DIFF = 8'd10;
  localparam reading_t RST_CROSS_MAX_DIFF         = 8'd10;
  localparam reading_t RST_CROSS_ENABLE_LEVEL     = 8'd5;
  localparam count_t   RST_PAIR_FAULT_LIMIT       = 8'd10;
  localparam count_t   RST_CROSS_FAULT_LIMIT      = 8'd10;

  localparam count_t COUNT_MAX = '1;

  typedef struct packed {
    reading_t pedal_pair_max_diff;
    reading_t throttle_pair_max_diff;
    reading_t cross_max_diff;
    reading_t cross_enable_level;
    count_t   pair_fault_limit;
    count_t   cross_fault_limit;
  } cfg_t;

  function automatic reading_t abs_diff(input reading_t a, input reading_t b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

  // Consecutive-fault run: clear on pass, count up and hold at the top on fail
  function automatic count_t next_run(input count_t run, input logic failed);
    if (!failed) begin
      next_run = '0;
    end else if (run == COUNT_MAX) begin
      next_run = COUNT_MAX;
    end else begin
      next_run = run + count_t'(1);
    end
  endfunction

endpackage

// ===== sv/throttle_plausibility_monitor.sv =====
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    mode, pedal_one/two, throttle_one/two
// out_     output     out_valid / out_stall  throttle_enable, fault_latched, *_fault_run
// cfg_     input      cfg_we (no handshake)  cfg_index, cfg_wdata
//
// Two register stages: an input register, then the result register.
// One item per cycle sustained while out_stall is low; an accepted item passes through the input
// register and then the result register, where out_valid marks it.
// All checks and counter updates sit between the input and result registers.
// rst_n is synchronous, active low; it clears held readings, counters, trip latch
// and restores the configuration defaults.
// in_stall rises only when both stages are full and out_stall holds the result register.
module throttle_plausibility_monitor
  import tpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,

  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  reading_t           in_pedal_one,
  input  reading_t           in_pedal_two,
  input  reading_t           in_throttle_one,
  input  reading_t           in_throttle_two,

  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_throttle_enable,
  output logic               out_fault_latched,
  output count_t             out_pedal_fault_run,
  output count_t             out_throttle_fault_run,
  output count_t             out_cross_fault_run,

  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [7:0]         cfg_wdata
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pedal_pair_max_diff    <= RST_PEDAL_PAIR_MAX_DIFF;
      cfg_r.throttle_pair_max_diff <= RST_THROTTLE_PAIR_MAX_DIFF;
      cfg_r.cross_max_diff         <= RST_CROSS_MAX_DIFF;
      cfg_r.cross_enable_level     <= RST_CROSS_ENABLE_LEVEL;
      cfg_r.pair_fault_limit       <= RST_PAIR_FAULT_LIMIT;
      cfg_r.cross_fault_limit      <= RST_CROSS_FAULT_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PEDAL_PAIR_MAX_DIFF:    cfg_r.pedal_pair_max_diff    <= cfg_wdata;
        REG_THROTTLE_PAIR_MAX_DIFF: cfg_r.throttle_pair_max_diff <= cfg_wdata;
        REG_CROSS_MAX_DIFF:         cfg_r.cross_max_diff         <= cfg_wdata;
        REG_CROSS_ENABLE_LEVEL:     cfg_r.cross_enable_level     <= cfg_wdata;
        REG_PAIR_FAULT_LIMIT:       cfg_r.pair_fault_limit       <= cfg_wdata;
        REG_CROSS_FAULT_LIMIT:      cfg_r.cross_fault_limit      <= cfg_wdata;
        default: ; // unused indexes are dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control
  // ---------------------------------------------------------------------------
  logic     s1_valid_r;
  logic     s1_mode_r;
  reading_t s1_p1_r, s1_p2_r, s1_t1_r, s1_t2_r;
  logic     out_valid_r;
  logic     out_ready;
  logic     s1_fire;
  logic     in_fire;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_ready;   // stage 1 moves into result register
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_fire   = in_valid && !in_stall;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_mode_r <= in_mode;
      s1_p1_r   <= in_pedal_one;
      s1_p2_r   <= in_pedal_two;
      s1_t1_r   <= in_throttle_one;
      s1_t2_r   <= in_throttle_two;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor state and check logic
  // ---------------------------------------------------------------------------
  reading_t held_p1_r, held_p2_r, held_t1_r, held_t2_r;
  count_t   pedal_cnt_r, throttle_cnt_r, cross_cnt_r;
  logic     trip_r;

  reading_t held_p1_nxt, held_p2_nxt, held_t1_nxt, held_t2_nxt;
  count_t   pedal_cnt_nxt, throttle_cnt_nxt, cross_cnt_nxt;
  logic     trip_nxt;

  logic     cross_on;
  logic     pedal_bad, throttle_bad, cross_bad;
  count_t   pedal_run, throttle_run, cross_run;
  logic     limit_hit;

  // Checks always run on held readings; only a tick commits them.
  always_comb begin
    cross_on     = (held_t1_r > cfg_r.cross_enable_level) ||
                   (held_t2_r > cfg_r.cross_enable_level);
    pedal_bad    = abs_diff(held_p1_r, held_p2_r) >= cfg_r.pedal_pair_max_diff;
    throttle_bad = abs_diff(held_t1_r, held_t2_r) >= cfg_r.throttle_pair_max_diff;
    cross_bad    = cross_on &&
                   (abs_diff(held_p1_r, held_t1_r) >= cfg_r.cross_max_diff);

    pedal_run    = next_run(pedal_cnt_r, pedal_bad);
    throttle_run = next_run(throttle_cnt_r, throttle_bad);
    cross_run    = next_run(cross_cnt_r, cross_bad);

    limit_hit    = (pedal_run >= cfg_r.pair_fault_limit) ||
                   (throttle_run >= cfg_r.pair_fault_limit) ||
                   (cross_run >= cfg_r.cross_fault_limit);

    held_p1_nxt      = held_p1_r;
    held_p2_nxt      = held_p2_r;
    held_t1_nxt      = held_t1_r;
    held_t2_nxt      = held_t2_r;
    pedal_cnt_nxt    = pedal_cnt_r;
    throttle_cnt_nxt = throttle_cnt_r;
    cross_cnt_nxt    = cross_cnt_r;
    trip_nxt         = trip_r;

    if (s1_fire) begin
      if (s1_mode_r == MODE_SENSOR) begin
        // sensor item: latch readings only
        held_p1_nxt = s1_p1_r;
        held_p2_nxt = s1_p2_r;
        held_t1_nxt = s1_t1_r;
        held_t2_nxt = s1_t2_r;
      end else begin
        pedal_cnt_nxt    = pedal_run;
        throttle_cnt_nxt = throttle_run;
        cross_cnt_nxt    = cross_run;
        trip_nxt         = trip_r || limit_hit;   // sticky until reset
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_p1_r      <= '0;
      held_p2_r      <= '0;
      held_t1_r      <= '0;
      held_t2_r      <= '0;
      pedal_cnt_r    <= '0;
      throttle_cnt_r <= '0;
      cross_cnt_r    <= '0;
      trip_r         <= 1'b0;
    end else begin
      held_p1_r      <= held_p1_nxt;
      held_p2_r      <= held_p2_nxt;
      held_t1_r      <= held_t1_nxt;
      held_t2_r      <= held_t2_nxt;
      pedal_cnt_r    <= pedal_cnt_nxt;
      throttle_cnt_r <= throttle_cnt_nxt;
      cross_cnt_r    <= cross_cnt_nxt;
      trip_r         <= trip_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: status as it stands after the item
  // ---------------------------------------------------------------------------
  logic   res_trip_r;
  count_t res_pedal_r, res_throttle_r, res_cross_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      res_trip_r     <= trip_nxt;
      res_pedal_r    <= pedal_cnt_nxt;
      res_throttle_r <= throttle_cnt_nxt;
      res_cross_r    <= cross_cnt_nxt;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_throttle_enable    = !res_trip_r;
  assign out_fault_latched      = res_trip_r;
  assign out_pedal_fault_run    = res_pedal_r;
  assign out_throttle_fault_run = res_throttle_r;
  assign out_cross_fault_run    = res_cross_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_trip_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    trip_r |=> trip_r)
    else $error("trip latch cleared without reset");

  a_sensor_keeps_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_mode_r == MODE_SENSOR) |=>
      ($stable(pedal_cnt_r) && $stable(throttle_cnt_r) && $stable(cross_cnt_r)
       && $stable(trip_r)))
    else $error("sensor item changed fault state");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with room in the pipeline");

  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> (res_trip_r == trip_r && res_pedal_r == pedal_cnt_r &&
                 res_throttle_r == throttle_cnt_r && res_cross_r == cross_cnt_r))
    else $error("result register disagrees with monitor state");

endmodule
